FILE: design/sdiv_pkg.sv
// Shared types for the signed non-restoring divider.
// Transaction structs for both channels and the tag that rides the cell chain.
// No dependencies.
`timescale 1ns / 1ps

package sdiv_pkg;

  localparam int unsigned FIELD_W = 32;

  typedef struct packed {
    logic signed [FIELD_W-1:0] dividend_in;
    logic signed [FIELD_W-1:0] divisor_in;
  } sdiv_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] quotient;
    logic signed [FIELD_W-1:0] remainder;
    logic                      div_by_zero;
    logic                      overflow;
  } sdiv_out_t;

  // Control that travels beside the data through every stage.
  typedef struct packed {
    logic valid;
    logic a_neg;
    logic q_neg;
    logic dz;
    logic ov;
  } sdiv_tag_t;

endpackage

FILE: design/sdiv_cell.sv
// One non-restoring division step: shift, then add or subtract the divisor.
// Depends on sdiv_pkg for the stage tag.
`timescale 1ns / 1ps

module sdiv_cell
  import sdiv_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sdiv_tag_t        tag_i,
  input  logic [WIDTH:0]   acc_i,
  input  logic [WIDTH-1:0] quo_i,
  input  logic [WIDTH-1:0] dvs_i,
  output sdiv_tag_t        tag_o,
  output logic [WIDTH:0]   acc_o,
  output logic [WIDTH-1:0] quo_o,
  output logic [WIDTH-1:0] dvs_o
);

  logic [WIDTH:0]   acc_sh;
  logic [WIDTH:0]   acc_d, acc_q;
  logic [WIDTH-1:0] quo_d, quo_q;
  logic [WIDTH-1:0] dvs_q;
  sdiv_tag_t        tag_q;

  always_comb begin
    acc_sh = {acc_i[WIDTH-1:0], quo_i[WIDTH-1]};
    // Accumulator sign picks the operation.
    if (acc_i[WIDTH]) begin
      acc_d = acc_sh + {1'b0, dvs_i};
    end else begin
      acc_d = acc_sh - {1'b0, dvs_i};
    end
    quo_d = {quo_i[WIDTH-2:0], ~acc_d[WIDTH]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    dvs_q <= dvs_i;
  end

  assign tag_o = tag_q;
  assign acc_o = acc_q;
  assign quo_o = quo_q;
  assign dvs_o = dvs_q;

endmodule

FILE: design/sdiv_post.sv
// Final restoring add, sign fixup and output register of the divider.
// Depends on sdiv_pkg for the tag and result transaction types.
`timescale 1ns / 1ps

module sdiv_post
  import sdiv_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sdiv_tag_t        tag_i,
  input  logic [WIDTH:0]   acc_i,
  input  logic [WIDTH-1:0] quo_i,
  input  logic [WIDTH-1:0] dvs_i,
  output logic             done_o,
  output sdiv_out_t        out_o
);

  logic [WIDTH:0]         rst_acc;
  logic [WIDTH-1:0]       rem_q;
  logic [WIDTH-1:0]       quo_q;
  sdiv_tag_t              tag_q;
  logic [WIDTH-1:0]       quo_fix, rem_fix;
  logic [WIDTH+FIELD_W-1:0] quo_ext, rem_ext;
  logic                   done_q;
  sdiv_out_t              out_d, out_q;

  // Restore a negative remainder.
  assign rst_acc = acc_i[WIDTH] ? (acc_i + {1'b0, dvs_i}) : acc_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= '0;
      done_q <= 1'b0;
    end else begin
      tag_q  <= tag_i;
      done_q <= tag_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rst_acc[WIDTH-1:0];
    quo_q <= quo_i;
    out_q <= out_d;
  end

  always_comb begin
    if (tag_q.dz) begin
      quo_fix = '1;
    end else if (tag_q.q_neg) begin
      quo_fix = '0 - quo_q;
    end else begin
      quo_fix = quo_q;
    end
    // Divide by zero leaves the dividend magnitude here; the sign fix restores it.
    rem_fix = tag_q.a_neg ? ('0 - rem_q) : rem_q;
    quo_ext = {{FIELD_W{quo_fix[WIDTH-1]}}, quo_fix};
    rem_ext = {{FIELD_W{rem_fix[WIDTH-1]}}, rem_fix};
    out_d.quotient    = quo_ext[FIELD_W-1:0];
    out_d.remainder   = rem_ext[FIELD_W-1:0];
    out_d.div_by_zero = tag_q.dz;
    out_d.overflow    = tag_q.ov;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

FILE: design/signed_nonrestoring_divider.sv
// Top level of the pipelined signed non-restoring divider.
// Depends on sdiv_pkg, sdiv_cell and sdiv_post.
//
// Usage:
//   Drive an operand pair on in_i and raise start_i; the transaction is taken
//   at any rising edge where start_i is high and busy_o is low. busy_o never
//   rises: the pipeline takes a new transaction in every cycle.
//   Each result appears on out_o for exactly one cycle with done_o high.
//   Results leave in the order their operands entered.
// Pipeline: one operand stage forms the magnitudes, a chain of
//   WIDTH cells performs one shift and add-or-subtract step each, one stage
//   applies the final restoring add and one stage fixes signs and holds the
//   output register.
// Throughput: one transaction per cycle, set by each cell doing one step.
// Reset: rst_ni clears every valid bit, so no stray results appear; data
//   registers are not reset.
// Stalls: the receiver cannot hold results off, so nothing ever backs up.
// Divisor zero gives quotient all ones and remainder equal to the dividend;
// most negative over minus one raises overflow and the quotient wraps.
`timescale 1ns / 1ps

module signed_nonrestoring_divider
  import sdiv_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  sdiv_in_t  in_i,
  output logic      done_o,
  output sdiv_out_t out_o
);

  logic [WIDTH+FIELD_W-1:0] a_ext, b_ext;
  logic [WIDTH-1:0]         op_a, op_b;
  logic [WIDTH-1:0]         mag_a, mag_b;
  sdiv_tag_t                tag_d;

  sdiv_tag_t                tag_q;
  logic [WIDTH-1:0]         mag_a_q, mag_b_q;

  sdiv_tag_t                tag_c [WIDTH+1];
  logic [WIDTH:0]           acc_c [WIDTH+1];
  logic [WIDTH-1:0]         quo_c [WIDTH+1];
  logic [WIDTH-1:0]         dvs_c [WIDTH+1];

  assign busy_o = 1'b0;

  // Take the low WIDTH bits of each field; zero-fill when WIDTH is wider.
  always_comb begin
    a_ext = {{WIDTH{1'b0}}, in_i.dividend_in};
    b_ext = {{WIDTH{1'b0}}, in_i.divisor_in};
    op_a  = a_ext[WIDTH-1:0];
    op_b  = b_ext[WIDTH-1:0];
    mag_a = op_a[WIDTH-1] ? ('0 - op_a) : op_a;
    mag_b = op_b[WIDTH-1] ? ('0 - op_b) : op_b;
    tag_d.valid = start_i && !busy_o;
    tag_d.a_neg = op_a[WIDTH-1];
    tag_d.q_neg = op_a[WIDTH-1] ^ op_b[WIDTH-1];
    tag_d.dz    = (op_b == '0);
    tag_d.ov    = (op_a == {1'b1, {(WIDTH-1){1'b0}}}) && (op_b == '1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_d;
    end
  end

  // Hold operand magnitudes for the first cell.
  always_ff @(posedge clk_i) begin
    mag_a_q <= mag_a;
    mag_b_q <= mag_b;
  end

  // Chain head: accumulator starts at zero, dividend sits in the quotient slot.
  assign tag_c[0] = tag_q;
  assign acc_c[0] = '0;
  assign quo_c[0] = mag_a_q;
  assign dvs_c[0] = mag_b_q;

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    sdiv_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tag_i (tag_c[i]),
      .acc_i (acc_c[i]),
      .quo_i (quo_c[i]),
      .dvs_i (dvs_c[i]),
      .tag_o (tag_c[i+1]),
      .acc_o (acc_c[i+1]),
      .quo_o (quo_c[i+1]),
      .dvs_o (dvs_c[i+1])
    );
  end

  sdiv_post #(
    .WIDTH(WIDTH)
  ) u_post (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tag_i (tag_c[WIDTH]),
    .acc_i (acc_c[WIDTH]),
    .quo_i (quo_c[WIDTH]),
    .dvs_i (dvs_c[WIDTH]),
    .done_o(done_o),
    .out_o (out_o)
  );

endmodule

FILE: tb/sv/signed_nonrestoring_divider_test.sv
// Self-checking testbench for the pipelined signed non-restoring divider.
// Predicts quotient, remainder and flags per operand pair; depends on sdiv_pkg.
// Directed corner cases first, then about 1300 random pairs with random idling.
`timescale 1ns / 1ps

module signed_nonrestoring_divider_test;
  import sdiv_pkg::*;

  localparam int unsigned WIDTH = 32;
  localparam logic [63:0] W_MASK = (WIDTH == 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
  localparam logic [63:0] W_SIGN = 64'd1 << (WIDTH - 1);
  // Pipeline depth from the top-level header; the final wait adds its own margin.
  localparam int unsigned LATENCY = WIDTH + 3;
  localparam int unsigned RANDOM_OPS = 1300;
  // Hold the sender here until every result in flight has come back.
  localparam int unsigned DRAIN_AT = 700;
  // Accepted-count window in which the sender never idles.
  localparam int unsigned QUIET_FROM = 200;
  localparam int unsigned QUIET_TO = 500;
  localparam logic signed [FIELD_W-1:0] MOST_NEG = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic signed [FIELD_W-1:0] MOST_POS = {1'b0, {(FIELD_W-1){1'b1}}};

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  logic      busy_o;
  sdiv_in_t  in_i = '0;
  logic      done_o;
  sdiv_out_t out_o;

  sdiv_in_t  pending_ops[$];
  sdiv_out_t expected_results[$];
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  logic        drain_done = 1'b0;

  signed_nonrestoring_divider #(
    .WIDTH(WIDTH)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .in_i   (in_i),
    .done_o (done_o),
    .out_o  (out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Compute what the divider must return for one operand pair: divide the
  // magnitudes, then fix the signs so the quotient truncates toward zero and
  // the remainder follows the dividend.
  function automatic sdiv_out_t divide_signed(sdiv_in_t op);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] q;
    logic [63:0] r;
    logic        a_neg;
    logic        b_neg;
    sdiv_out_t   res;
    a = 64'(unsigned'(op.dividend_in)) & W_MASK;
    b = 64'(unsigned'(op.divisor_in)) & W_MASK;
    a_neg = (a & W_SIGN) != 0;
    b_neg = (b & W_SIGN) != 0;
    res.div_by_zero = 1'b0;
    res.overflow = 1'b0;
    if (b == 0) begin
      // Divide by zero: all-ones quotient, dividend passes through.
      q = W_MASK;
      r = a;
      res.div_by_zero = 1'b1;
    end else begin
      mag_a = a_neg ? ((64'd0 - a) & W_MASK) : a;
      mag_b = b_neg ? ((64'd0 - b) & W_MASK) : b;
      q = mag_a / mag_b;
      r = mag_a % mag_b;
      if (a_neg != b_neg) q = 64'd0 - q;
      if (a_neg) r = 64'd0 - r;
      // Most negative over minus one: the quotient wraps back to itself.
      res.overflow = (a == W_SIGN) && (b == W_MASK);
    end
    q = (((q & W_MASK) ^ W_SIGN) - W_SIGN);
    r = (((r & W_MASK) ^ W_SIGN) - W_SIGN);
    res.quotient = q[FIELD_W-1:0];
    res.remainder = r[FIELD_W-1:0];
    return res;
  endfunction

  // Draw one operand of a random kind; small and short values reach the
  // quotient bits that full-width random values rarely exercise.
  function automatic logic signed [FIELD_W-1:0] random_operand(int unsigned kind);
    logic [FIELD_W-1:0] v;
    case (kind)
      0: begin
        v = $urandom;
      end
      1: begin
        v = FIELD_W'(int'($urandom_range(0, 200)) - 100);
      end
      2: begin
        v = $urandom >> $urandom_range(0, FIELD_W - 1);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        // Land on or next to the extremes.
        case ($urandom_range(0, 5))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = MOST_NEG + 1;
          3: v = '1;
          4: v = 1;
          default: v = 0;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic sdiv_in_t make_op(logic signed [FIELD_W-1:0] dividend,
                                       logic signed [FIELD_W-1:0] divisor);
    sdiv_in_t op;
    op.dividend_in = dividend;
    op.divisor_in = divisor;
    return op;
  endfunction

  task automatic report_mismatch(string field, logic [FIELD_W-1:0] exp_v,
                                 logic [FIELD_W-1:0] act_v);
    $error("%s mismatch: expected %0h, actual %0h", field, exp_v, act_v);
    mismatch_count++;
  endtask

  // Driver: record each accepted transaction, then present the next pending
  // pair unless this cycle idles or the sender is held for a full drain.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic pause;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      pause = 1'b0;
      if (start_i && !busy_o) begin
        expected_results.push_back(divide_signed(in_i));
        void'(pending_ops.pop_front());
        accepted_count++;
      end
      // Hold the presented pair while the block is busy.
      if (!(start_i && busy_o)) begin
        if (accepted_count == DRAIN_AT && !drain_done) begin
          if (expected_results.size() == 0) begin
            drain_done = 1'b1;
          end else begin
            pause = 1'b1;
          end
        end
        if (!pause && (accepted_count < QUIET_FROM || accepted_count > QUIET_TO)) begin
          pause = ($urandom_range(0, 99) < 14);
        end
        if (pause || pending_ops.size() == 0) begin
          start_i <= 1'b0;
        end else begin
          start_i <= 1'b1;
          in_i <= pending_ops[0];
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest outstanding prediction.
  always @(posedge clk_i) begin : monitor
    sdiv_out_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result without an outstanding transaction: %0h", out_o);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_o.quotient !== exp_r.quotient)
          report_mismatch("quotient", exp_r.quotient, out_o.quotient);
        if (out_o.remainder !== exp_r.remainder)
          report_mismatch("remainder", exp_r.remainder, out_o.remainder);
        if (out_o.div_by_zero !== exp_r.div_by_zero)
          report_mismatch("div_by_zero", FIELD_W'(exp_r.div_by_zero),
                          FIELD_W'(out_o.div_by_zero));
        if (out_o.overflow !== exp_r.overflow)
          report_mismatch("overflow", FIELD_W'(exp_r.overflow),
                          FIELD_W'(out_o.overflow));
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int unsigned kind;
    // Directed corners: zero divisors, the overflow pair, extremes, all four
    // sign combinations and a zero dividend.
    pending_ops.push_back(make_op(0, 0));
    pending_ops.push_back(make_op(1, 0));
    pending_ops.push_back(make_op(-1, 0));
    pending_ops.push_back(make_op(MOST_NEG, 0));
    pending_ops.push_back(make_op(MOST_POS, 0));
    pending_ops.push_back(make_op(MOST_NEG, -1));
    pending_ops.push_back(make_op(MOST_NEG, 1));
    pending_ops.push_back(make_op(MOST_POS, -1));
    pending_ops.push_back(make_op(MOST_POS, MOST_POS));
    pending_ops.push_back(make_op(MOST_NEG, MOST_NEG));
    pending_ops.push_back(make_op(MOST_POS, MOST_NEG));
    pending_ops.push_back(make_op(MOST_NEG, MOST_POS));
    pending_ops.push_back(make_op(7, 2));
    pending_ops.push_back(make_op(-7, 2));
    pending_ops.push_back(make_op(7, -2));
    pending_ops.push_back(make_op(-7, -2));
    pending_ops.push_back(make_op(0, 5));
    pending_ops.push_back(make_op(5, 7));
    pending_ops.push_back(make_op(-5, 7));
    pending_ops.push_back(make_op(1, 1));
    pending_ops.push_back(make_op(-1, -1));
    pending_ops.push_back(make_op(MOST_NEG, 2));
    pending_ops.push_back(make_op(MOST_NEG + 1, -1));
    pending_ops.push_back(make_op('1, MOST_NEG));
    for (int i = 0; i < RANDOM_OPS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        pending_ops.push_back(make_op(random_operand(0), random_operand(0)));
      end else if (kind < 55) begin
        pending_ops.push_back(make_op(random_operand(1), random_operand(1)));
      end else if (kind < 80) begin
        pending_ops.push_back(make_op(random_operand($urandom_range(0, 2)),
                                      random_operand(2)));
      end else if (kind < 88) begin
        pending_ops.push_back(make_op(random_operand($urandom_range(0, 3)), 0));
      end else begin
        pending_ops.push_back(make_op(random_operand($urandom_range(0, 3)),
                                      random_operand($urandom_range(0, 3))));
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every pair to be taken, then for every result to come back.
    while (pending_ops.size() != 0 || start_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    // Give stray results time to surface.
    repeat (LATENCY + 8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Abort a hung run well beyond the slowest legal completion.
  initial begin : watchdog
    #500000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
